// ----- src/ohacc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohacc_pkg
// Shared types and constants of the orientation histogram accumulator.
// ----------------------------------------------------------------------------
package ohacc_pkg;

  // sequencer states of the core
  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_READ_WAIT,
    S_SQ,
    S_SQRT,
    S_BIN,
    S_BMUL,
    S_BDIV,
    S_UDIV,
    S_UWAIT,
    S_DOT,
    S_ANG,
    S_HRD,
    S_HINC,
    S_DONE
  } state_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_REF_X,
    REG_REF_Y,
    REG_REF_Z,
    REG_MIN_RADIUS,
    REG_MAX_RADIUS,
    REG_RADIAL_BINS,
    REG_HALF_BOX,
    REG_RADIAL_BINNED
  } reg_e;

  // histogram store control, core to store
  typedef struct packed {
    logic rd;
    logic inc_u;
    logic inc_v;
    logic inc_w;
    logic inc_mol;
  } hist_ctl_t;

  localparam logic       CMD_READ   = 1'b1;
  localparam logic [1:0] AXIS_U     = 2'd0;
  localparam logic [1:0] AXIS_V     = 2'd1;
  localparam logic [1:0] AXIS_W     = 2'd2;
  localparam int         UNIT_STEPS = 25;
  localparam int         ANGLE_SHIFT = 49;
  localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;

endpackage

// ----- src/ohacc_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohacc_in_if
// Input channel: one sample or read request word.
// ----------------------------------------------------------------------------
interface ohacc_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [1:0]         axis_sel;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic [3:0]         read_radial;
  logic [6:0]         read_angle;

  modport source (
    output valid, cmd, axis_sel, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
           read_radial, read_angle,
    input  ready
  );
  modport sink (
    input  valid, cmd, axis_sel, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
           read_radial, read_angle,
    output ready
  );
endinterface

// ----- src/ohacc_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohacc_out_if
// Output channel: one result word per input word.
// ----------------------------------------------------------------------------
interface ohacc_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [3:0]  radial_bin;
  logic [6:0]  angle_bin;
  logic [31:0] count_u;
  logic [31:0] count_v;
  logic [31:0] count_w;
  logic [31:0] molecule_count;

  modport source (
    output valid, accepted, radial_bin, angle_bin, count_u, count_v, count_w,
           molecule_count,
    input  ready
  );
  modport sink (
    input  valid, accepted, radial_bin, angle_bin, count_u, count_v, count_w,
           molecule_count,
    output ready
  );
endinterface

// ----- src/ohacc_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohacc_sqrt
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module ohacc_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] x_q, res_q, bit_q;
  logic [64:0] trial;
  logic        busy_q, done_q;

  // trial subtract of the current candidate
  assign trial = {1'b0, x_q} - ({1'b0, res_q} + {1'b0, bit_q});

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q == 64'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // root recurrence
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      res_q <= '0;
      bit_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (!trial[64]) begin
        x_q   <= trial[63:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

// ----- src/ohacc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohacc_div
// Restoring divider, one quotient bit per cycle, for a preset step count.
// ----------------------------------------------------------------------------
module ohacc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] rem_i,
  input  logic [31:0] low_i,
  input  logic [5:0]  steps_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic [31:0] rem_q, low_q, den_q, quot_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] shifted, diff;

  // shift in the next dividend bit and try the subtract
  assign shifted = {rem_q, low_q[31]};
  assign diff    = shifted - {1'b0, den_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == 6'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // quotient recurrence
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      low_q  <= low_i;
      den_q  <= den_i;
      quot_q <= '0;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      rem_q  <= diff[32] ? shifted[31:0] : diff[31:0];
      quot_q <= {quot_q[30:0], ~diff[32]};
      low_q  <= low_q << 1;
      cnt_q  <= cnt_q - 6'd1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- src/ohacc_hist.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohacc_hist
// Histogram stores for the three axes and the molecule counts, with
// saturating increment and a clearing pass after reset.
// ----------------------------------------------------------------------------
module ohacc_hist import ohacc_pkg::*; #(
  parameter  int ANGLE_BINS      = 100,
  parameter  int MAX_RADIAL_BINS = 16,
  localparam int DEPTH = ANGLE_BINS * MAX_RADIAL_BINS,
  localparam int DAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int RBW   = (MAX_RADIAL_BINS > 1) ? $clog2(MAX_RADIAL_BINS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hist_ctl_t       ctl_i,
  input  logic [DAW-1:0]  addr_i,
  input  logic [RBW-1:0]  rb_i,
  output logic [31:0]     cnt_u_o,
  output logic [31:0]     cnt_v_o,
  output logic [31:0]     cnt_w_o,
  output logic [31:0]     mol_o,
  output logic            clr_busy_o
);

  logic [31:0] mem_u [DEPTH];
  logic [31:0] mem_v [DEPTH];
  logic [31:0] mem_w [DEPTH];
  logic [31:0] mol_q [MAX_RADIAL_BINS];
  logic [31:0] rd_u_q, rd_v_q, rd_w_q, rd_m_q;
  logic [DAW-1:0] clr_idx_q;
  logic           clr_busy_q;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

  // clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == DAW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
    end
  end

  // u store
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_u[clr_idx_q] <= '0;
    end else if (ctl_i.inc_u) begin
      mem_u[addr_i] <= sat_inc(rd_u_q);
    end
    if (ctl_i.rd) begin
      rd_u_q <= mem_u[addr_i];
    end
  end

  // v store
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_v[clr_idx_q] <= '0;
    end else if (ctl_i.inc_v) begin
      mem_v[addr_i] <= sat_inc(rd_v_q);
    end
    if (ctl_i.rd) begin
      rd_v_q <= mem_v[addr_i];
    end
  end

  // w store
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_w[clr_idx_q] <= '0;
    end else if (ctl_i.inc_w) begin
      mem_w[addr_i] <= sat_inc(rd_w_q);
    end
    if (ctl_i.rd) begin
      rd_w_q <= mem_w[addr_i];
    end
  end

  // molecule counts per radial bin
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      if (int'(clr_idx_q) < MAX_RADIAL_BINS) begin
        mol_q[RBW'(clr_idx_q)] <= '0;
      end
    end else if (ctl_i.inc_mol) begin
      mol_q[rb_i] <= sat_inc(rd_m_q);
    end
    if (ctl_i.rd) begin
      rd_m_q <= mol_q[rb_i];
    end
  end

  assign cnt_u_o    = rd_u_q;
  assign cnt_v_o    = rd_v_q;
  assign cnt_w_o    = rd_w_q;
  assign mol_o      = rd_m_q;
  assign clr_busy_o = clr_busy_q;

endmodule

// ----- src/orientation_histogram_accumulator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orientation_histogram_accumulator_core
// Bins particle axis samples by radial distance and cosine to the radial
// direction, and reads the resulting histograms back.
// ----------------------------------------------------------------------------
// The block takes one word at a time. A sample word runs through one shared
// multiplier, one iterative square root (run on the radius and, for a kept
// sample, on the direction) and one shared restoring divider (for each of
// six unit components, and for the radial bin in radial-binned mode); a
// sample dropped by the radius window or the bin range leaves after the
// radius check. After reset the histogram stores are cleared one entry per
// cycle, all ANGLE_BINS * MAX_RADIAL_BINS entries (1600 by default), and no
// word is taken until that sweep ends; configuration writes are taken at any
// time. Counts saturate at 2^32 - 1.
module orientation_histogram_accumulator_core import ohacc_pkg::*; #(
  parameter int ANGLE_BINS      = 100,
  parameter int MAX_RADIAL_BINS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ohacc_in_if.sink    in_i,
  ohacc_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = ANGLE_BINS * MAX_RADIAL_BINS;
  localparam int DAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RBW   = (MAX_RADIAL_BINS > 1) ? $clog2(MAX_RADIAL_BINS) : 1;
  localparam int ABW   = $clog2(ANGLE_BINS);
  localparam int NBW   = RBW + 1;
  localparam logic signed [65:0] COS_ONE = 66'sh1_0000_0000_0000;

  // configuration registers
  logic signed [31:0] ref_x_q, ref_y_q, ref_z_q;
  logic [30:0] min_radius_q, max_radius_q, half_box_q;
  logic [4:0]  radial_bins_q;
  logic        radial_binned_q;
  logic        cfg_wr;
  reg_e        cfg_idx;

  // sequencer and datapath
  state_e state_q, state_d;
  logic               in_fire;
  logic [1:0]         axis_q;
  logic [3:0]         ra_q;
  logic [6:0]         aa_q;
  logic signed [31:0] r_q [3];
  logic signed [31:0] d_q [3];
  logic signed [25:0] er_q [3];
  logic signed [25:0] ed_q [3];
  logic [1:0]         cnt_q;
  logic               sel_d_q;
  logic signed [65:0] acc_q, mul_q;
  logic signed [32:0] mul_a, mul_b;
  logic [31:0]        lr_q, ld_q;
  logic [RBW-1:0]     rb_q;
  logic [ABW-1:0]     ab_c;

  // staged and output result
  logic        st_acc_q;
  logic [3:0]  st_rb_q;
  logic [6:0]  st_ab_q;
  logic [31:0] st_cu_q, st_cv_q, st_cw_q, st_cm_q;
  logic        out_valid_q, out_go;
  logic        res_acc_q;
  logic [3:0]  res_rb_q;
  logic [6:0]  res_ab_q;
  logic [31:0] res_cu_q, res_cv_q, res_cw_q, res_cm_q;

  // shared units
  logic        sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;
  logic        div_start, div_done;
  logic [31:0] div_rem, div_low, div_den, div_quot;
  logic [5:0]  div_steps;
  hist_ctl_t   hctl;
  logic [DAW-1:0] h_addr;
  logic [RBW-1:0] h_rb;
  logic [31:0] h_cu, h_cv, h_cw, h_cm;
  logic        clr_busy;

  // combinational helpers
  logic signed [31:0] cur_v;
  logic [31:0]        cur_mag, cur_len;
  logic [NBW-1:0]     nb_c;
  logic               drop_c, ra_ok, rd_ok, axis_ok, last_comp;
  logic [63:0]        prod_u, t_u, scaled;
  logic signed [65:0] t_c;
  logic [14:0]        ab_raw;
  logic signed [25:0] q_s, e_c;

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [32:0] diff;
    diff = {a[31], a} - {b[31], b};
    if (diff[32] != diff[31]) begin
      return diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return diff[31:0];
  endfunction

  function automatic logic [31:0] mag(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // apb register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q         <= '0;
      ref_y_q         <= '0;
      ref_z_q         <= '0;
      min_radius_q    <= '0;
      max_radius_q    <= '0;
      radial_bins_q   <= 5'd1;
      half_box_q      <= 31'd65536;
      radial_binned_q <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_REF_X:         ref_x_q         <= pwdata;
        REG_REF_Y:         ref_y_q         <= pwdata;
        REG_REF_Z:         ref_z_q         <= pwdata;
        REG_MIN_RADIUS:    min_radius_q    <= pwdata[30:0];
        REG_MAX_RADIUS:    max_radius_q    <= pwdata[30:0];
        REG_RADIAL_BINS:   radial_bins_q   <= pwdata[4:0];
        REG_HALF_BOX:      half_box_q      <= pwdata[30:0];
        REG_RADIAL_BINNED: radial_binned_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_REF_X:         prdata = ref_x_q;
      REG_REF_Y:         prdata = ref_y_q;
      REG_REF_Z:         prdata = ref_z_q;
      REG_MIN_RADIUS:    prdata = {1'b0, min_radius_q};
      REG_MAX_RADIUS:    prdata = {1'b0, max_radius_q};
      REG_RADIAL_BINS:   prdata = {27'd0, radial_bins_q};
      REG_HALF_BOX:      prdata = {1'b0, half_box_q};
      REG_RADIAL_BINNED: prdata = {31'd0, radial_binned_q};
      default:           prdata = '0;
    endcase
  end

  // handshakes
  assign in_i.ready = (state_q == S_IDLE) & ~clr_busy;
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_go     = ~out_valid_q | out_o.ready;

  // component currently under the multiplier or divider
  always_comb begin
    cur_v = '0;
    if (cnt_q != 2'd3) begin
      cur_v = sel_d_q ? d_q[cnt_q] : r_q[cnt_q];
    end
  end
  assign cur_mag   = mag(cur_v);
  assign cur_len   = sel_d_q ? ld_q : lr_q;
  assign last_comp = (cnt_q == 2'd2) & sel_d_q;

  // radial bin range and drop decision
  assign nb_c = (int'(radial_bins_q) > MAX_RADIAL_BINS) ? NBW'(MAX_RADIAL_BINS)
                                                        : NBW'(radial_bins_q);
  always_comb begin
    if (radial_binned_q) begin
      drop_c = (half_box_q == '0) || (nb_c == '0) || (lr_q >= {1'b0, half_box_q});
    end else begin
      drop_c = !((lr_q > {1'b0, min_radius_q}) && (lr_q < {1'b0, max_radius_q}));
    end
  end

  // read address checks
  assign ra_ok   = int'(ra_q) < MAX_RADIAL_BINS;
  assign rd_ok   = ra_ok && (int'(aa_q) < ANGLE_BINS);
  assign axis_ok = (axis_q == AXIS_U) || (axis_q == AXIS_V) || (axis_q == AXIS_W);

  // cosine to angle bin
  assign t_c    = acc_q + COS_ONE;
  assign t_u    = t_c[65] ? '0 : t_c[63:0];
  assign scaled = t_u * 64'(ANGLE_BINS);
  assign ab_raw = scaled[63:ANGLE_SHIFT];
  assign ab_c   = (int'(ab_raw) >= ANGLE_BINS) ? ABW'(ANGLE_BINS - 1) : ABW'(ab_raw);

  // signed unit component from the divider quotient
  assign q_s = {1'b0, div_quot[24:0]};
  assign e_c = cur_v[31] ? -q_s : q_s;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ: begin
        mul_a = {1'b0, cur_mag};
        mul_b = {1'b0, cur_mag};
      end
      S_BIN: begin
        mul_a = {1'b0, lr_q};
        mul_b = 33'(nb_c);
      end
      S_DOT: begin
        if (cnt_q != 2'd3) begin
          mul_a = 33'(er_q[cnt_q]);
          mul_b = 33'(ed_q[cnt_q]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // divider operands
  assign prod_u = mul_q[63:0];
  always_comb begin
    if (state_q == S_BMUL) begin
      div_rem   = prod_u[RBW +: 32];
      div_low   = {prod_u[RBW-1:0], {(32 - RBW){1'b0}}};
      div_steps = 6'(RBW);
      div_den   = {1'b0, half_box_q};
    end else begin
      div_rem   = {1'b0, cur_mag[31:1]};
      div_low   = {cur_mag[0], 31'd0};
      div_steps = 6'(UNIT_STEPS);
      div_den   = cur_len;
    end
  end

  // histogram address
  always_comb begin
    if (state_q == S_READ) begin
      h_addr = rd_ok ? DAW'(int'(ra_q) * ANGLE_BINS + int'(aa_q)) : '0;
      h_rb   = ra_ok ? RBW'(ra_q) : '0;
    end else begin
      h_addr = DAW'(int'(rb_q) * ANGLE_BINS + int'(ab_c));
      h_rb   = rb_q;
    end
  end

  // sequencer next state
  always_comb begin
    state_d    = state_q;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    hctl       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.cmd == CMD_READ) ? S_READ : S_SQ;
        end
      end
      S_READ: begin
        hctl.rd = 1'b1;
        state_d = S_READ_WAIT;
      end
      S_READ_WAIT: state_d = S_DONE;
      S_SQ: begin
        if (cnt_q == 2'd3) begin
          sqrt_start = 1'b1;
          state_d    = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          state_d = sel_d_q ? S_UDIV : S_BIN;
        end
      end
      S_BIN: begin
        if (drop_c) begin
          state_d = S_DONE;
        end else if (radial_binned_q) begin
          state_d = S_BMUL;
        end else begin
          state_d = S_SQ;
        end
      end
      S_BMUL: begin
        div_start = 1'b1;
        state_d   = S_BDIV;
      end
      S_BDIV: begin
        if (div_done) begin
          state_d = S_SQ;
        end
      end
      S_UDIV: begin
        if (cur_len == '0) begin
          if (last_comp) begin
            state_d = S_DOT;
          end
        end else begin
          div_start = 1'b1;
          state_d   = S_UWAIT;
        end
      end
      S_UWAIT: begin
        if (div_done) begin
          state_d = last_comp ? S_DOT : S_UDIV;
        end
      end
      S_DOT: begin
        if (cnt_q == 2'd3) begin
          state_d = S_ANG;
        end
      end
      S_ANG: state_d = axis_ok ? S_HRD : S_DONE;
      S_HRD: begin
        hctl.rd = 1'b1;
        state_d = S_HINC;
      end
      S_HINC: begin
        hctl.inc_u   = (axis_q == AXIS_U);
        hctl.inc_mol = (axis_q == AXIS_U);
        hctl.inc_v   = (axis_q == AXIS_V);
        hctl.inc_w   = (axis_q == AXIS_W);
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (out_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          axis_q  <= in_i.axis_sel;
          ra_q    <= in_i.read_radial;
          aa_q    <= in_i.read_angle;
          r_q[0]  <= sat_sub(in_i.pos_x, ref_x_q);
          r_q[1]  <= sat_sub(in_i.pos_y, ref_y_q);
          r_q[2]  <= sat_sub(in_i.pos_z, ref_z_q);
          d_q[0]  <= in_i.dir_x;
          d_q[1]  <= in_i.dir_y;
          d_q[2]  <= in_i.dir_z;
          cnt_q   <= 2'd0;
          sel_d_q <= 1'b0;
        end
      end
      S_READ_WAIT: begin
        st_acc_q <= 1'b0;
        st_rb_q  <= ra_q;
        st_ab_q  <= aa_q;
        st_cu_q  <= rd_ok ? h_cu : '0;
        st_cv_q  <= rd_ok ? h_cv : '0;
        st_cw_q  <= rd_ok ? h_cw : '0;
        st_cm_q  <= ra_ok ? h_cm : '0;
      end
      S_SQ, S_DOT: begin
        acc_q <= (cnt_q == 2'd0) ? '0 : acc_q + mul_q;
        cnt_q <= cnt_q + 2'd1;
      end
      S_SQRT: begin
        if (sqrt_done) begin
          if (sel_d_q) begin
            ld_q    <= sqrt_root;
            sel_d_q <= 1'b0;
          end else begin
            lr_q <= sqrt_root;
          end
        end
      end
      S_BIN: begin
        // dropped samples report zero bins
        st_acc_q <= 1'b0;
        st_rb_q  <= '0;
        st_ab_q  <= '0;
        st_cu_q  <= '0;
        st_cv_q  <= '0;
        st_cw_q  <= '0;
        st_cm_q  <= '0;
        if (!radial_binned_q) begin
          rb_q    <= '0;
          sel_d_q <= 1'b1;
        end
      end
      S_BDIV: begin
        if (div_done) begin
          rb_q    <= RBW'(div_quot);
          sel_d_q <= 1'b1;
        end
      end
      S_UDIV, S_UWAIT: begin
        if ((state_q == S_UDIV && cur_len == '0) || (state_q == S_UWAIT && div_done)) begin
          if (sel_d_q) begin
            ed_q[cnt_q] <= (cur_len == '0) ? '0 : e_c;
          end else begin
            er_q[cnt_q] <= (cur_len == '0) ? '0 : e_c;
          end
          if (cnt_q == 2'd2) begin
            cnt_q   <= 2'd0;
            sel_d_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 2'd1;
          end
        end
      end
      S_ANG: begin
        st_rb_q <= 4'(rb_q);
        st_ab_q <= 7'(ab_c);
      end
      S_HINC: st_acc_q <= 1'b1;
      S_DONE: begin
        if (out_go) begin
          res_acc_q <= st_acc_q;
          res_rb_q  <= st_rb_q;
          res_ab_q  <= st_ab_q;
          res_cu_q  <= st_cu_q;
          res_cv_q  <= st_cv_q;
          res_cw_q  <= st_cw_q;
          res_cm_q  <= st_cm_q;
        end
      end
      default: ;
    endcase
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.accepted       = res_acc_q;
  assign out_o.radial_bin     = res_rb_q;
  assign out_o.angle_bin      = res_ab_q;
  assign out_o.count_u        = res_cu_q;
  assign out_o.count_v        = res_cv_q;
  assign out_o.count_w        = res_cw_q;
  assign out_o.molecule_count = res_cm_q;

  // shared square root
  ohacc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (acc_q[63:0] + mul_q[63:0]),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // shared divider
  ohacc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .low_i   (div_low),
    .steps_i (div_steps),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // histogram stores
  ohacc_hist #(
    .ANGLE_BINS      (ANGLE_BINS),
    .MAX_RADIAL_BINS (MAX_RADIAL_BINS)
  ) u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (hctl),
    .addr_i     (h_addr),
    .rb_i       (h_rb),
    .cnt_u_o    (h_cu),
    .cnt_v_o    (h_cv),
    .cnt_w_o    (h_cw),
    .mol_o      (h_cm),
    .clr_busy_o (clr_busy)
  );

`ifndef SYNTH
  // no word is taken while the stores are being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_i.ready |-> !clr_busy)
    else $error("input ready during clearing pass");

  // an increment always follows the read of the same entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HINC |-> $past(state_q) == S_HRD)
    else $error("increment without preceding read");

  // at most one axis store is raised per sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({hctl.inc_u, hctl.inc_v, hctl.inc_w}))
    else $error("more than one axis store raised");
`endif

endmodule
